FILE: hdl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg: shared types, constants and term tables
// Widths, ASCII symbol codes and the greedy term table (weight, first and
// second letter) used by the Roman numeral encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

   localparam int ValueWidth   = 12;
   localparam int LetterWidth  = 7;
   localparam int MaxValue     = 3999;
   localparam int NumTerms     = 13;
   localparam int TermIdxWidth = $clog2(NumTerms);
   localparam int QueueDepth   = 2;

   // ASCII symbol codes
   localparam logic [LetterWidth-1:0] LetterNone = 7'h00;
   localparam logic [LetterWidth-1:0] LetterI    = 7'h49;
   localparam logic [LetterWidth-1:0] LetterV    = 7'h56;
   localparam logic [LetterWidth-1:0] LetterX    = 7'h58;
   localparam logic [LetterWidth-1:0] LetterL    = 7'h4C;
   localparam logic [LetterWidth-1:0] LetterC    = 7'h43;
   localparam logic [LetterWidth-1:0] LetterD    = 7'h44;
   localparam logic [LetterWidth-1:0] LetterM    = 7'h4D;

   // Queue entry: a nonzero value, flagged when out of range
   typedef struct packed {
      logic                  err;
      logic [ValueWidth-1:0] value;
   } item_type;

   // Term table, largest weight first
   function automatic logic [ValueWidth-1:0] term_weight(input logic [TermIdxWidth-1:0] idx);
      case (idx)
         4'd0:    term_weight = 12'd1000;
         4'd1:    term_weight = 12'd900;
         4'd2:    term_weight = 12'd500;
         4'd3:    term_weight = 12'd400;
         4'd4:    term_weight = 12'd100;
         4'd5:    term_weight = 12'd90;
         4'd6:    term_weight = 12'd50;
         4'd7:    term_weight = 12'd40;
         4'd8:    term_weight = 12'd10;
         4'd9:    term_weight = 12'd9;
         4'd10:   term_weight = 12'd5;
         4'd11:   term_weight = 12'd4;
         4'd12:   term_weight = 12'd1;
         default: term_weight = 12'd1;
      endcase
   endfunction

   function automatic logic [LetterWidth-1:0] term_first(input logic [TermIdxWidth-1:0] idx);
      case (idx)
         4'd0:    term_first = LetterM;
         4'd1:    term_first = LetterC;
         4'd2:    term_first = LetterD;
         4'd3:    term_first = LetterC;
         4'd4:    term_first = LetterC;
         4'd5:    term_first = LetterX;
         4'd6:    term_first = LetterL;
         4'd7:    term_first = LetterX;
         4'd8:    term_first = LetterX;
         4'd9:    term_first = LetterI;
         4'd10:   term_first = LetterV;
         4'd11:   term_first = LetterI;
         4'd12:   term_first = LetterI;
         default: term_first = LetterI;
      endcase
   endfunction

   // LetterNone for single-symbol terms
   function automatic logic [LetterWidth-1:0] term_second(input logic [TermIdxWidth-1:0] idx);
      case (idx)
         4'd1:    term_second = LetterM;
         4'd3:    term_second = LetterD;
         4'd5:    term_second = LetterC;
         4'd7:    term_second = LetterL;
         4'd9:    term_second = LetterX;
         4'd11:   term_second = LetterV;
         default: term_second = LetterNone;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: hdl/rne_if.sv
// ----------------------------------------------------------------------------
// rne_if: request and response channels
// Valid/ready channels carrying the value to encode and the emitted letters.
// ----------------------------------------------------------------------------
`default_nettype none

interface rne_req_if;
   logic                           valid;
   logic                           ready;
   logic [rne_pkg::ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rne_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rne_pkg::LetterWidth-1:0] letter;
   logic                            last;
   logic                            error;

   modport source (output valid, output letter, output last, output error, input ready);
   modport sink   (input valid, input letter, input last, input error, output ready);
endinterface

`default_nettype wire

FILE: hdl/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front: request intake and classification
// Takes request beats while the queue has room, drops zero values and tags
// values above the numeral range before queuing them.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_front (
   rne_req_if.sink            req_bus,
   input  wire logic          queue_full,
   output logic               push,
   output rne_pkg::item_type  push_item
);

   logic is_zero;

   assign is_zero             = (req_bus.value == '0);
   assign req_bus.ready       = !queue_full;
   assign push                = req_bus.valid && !queue_full && !is_zero;
   assign push_item.value     = req_bus.value;
   assign push_item.err       = (req_bus.value > rne_pkg::ValueWidth'(rne_pkg::MaxValue));

endmodule

`default_nettype wire

FILE: hdl/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue: classified item queue
// Small FIFO between intake and letter emission.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_queue #(
   parameter int Depth = rne_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  rne_pkg::item_type      push_item,
   output logic                   full,
   input  wire logic              pop,
   output rne_pkg::item_type      pop_item,
   output logic                   empty
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   rne_pkg::item_type     entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // occupancy never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("queue occupancy above depth");

endmodule

`default_nettype wire

FILE: hdl/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back: letter emitter
// Pops one item, then emits one letter per cycle while the registered
// response stage is free, by greedy subtraction of the largest fitting term.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          queue_empty,
   input  rne_pkg::item_type  pop_item,
   output logic               pop,
   rne_rsp_if.source          rsp_bus
);

   localparam int TW = rne_pkg::TermIdxWidth;
   localparam int VW = rne_pkg::ValueWidth;
   localparam int LW = rne_pkg::LetterWidth;

   logic          busy_ff, busy_in;
   logic          err_ff, err_in;
   logic          second_ff, second_in;
   logic [TW-1:0] term_ff, term_in;
   logic [VW-1:0] rest_ff, rest_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] letter_ff, letter_in;
   logic          last_ff, last_in;
   logic          error_ff, error_in;

   logic          out_free, emit;
   logic [TW-1:0] pick;
   logic [TW-1:0] cur_term;
   logic [VW-1:0] rest_after;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = busy_ff && out_free;
   assign pop      = !busy_ff && !queue_empty;

   // largest term not above the remainder
   always_comb begin
      pick = TW'(rne_pkg::NumTerms - 1);
      for (int i = rne_pkg::NumTerms - 1; i >= 0; i--) begin
         if (rest_ff >= rne_pkg::term_weight(TW'(i))) begin
            pick = TW'(i);
         end
      end
   end

   assign cur_term   = second_ff ? term_ff : pick;
   assign rest_after = rest_ff - rne_pkg::term_weight(cur_term);

   always_comb begin
      busy_in      = busy_ff;
      err_in       = err_ff;
      second_in    = second_ff;
      term_in      = term_ff;
      rest_in      = rest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      letter_in    = letter_ff;
      last_in      = last_ff;
      error_in     = error_ff;
      if (pop) begin
         busy_in   = 1'b1;
         err_in    = pop_item.err;
         second_in = 1'b0;
         rest_in   = pop_item.value;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            letter_in = rne_pkg::LetterNone;
            last_in   = 1'b1;
            error_in  = 1'b1;
            busy_in   = 1'b0;
         end else if (second_ff) begin
            letter_in = rne_pkg::term_second(term_ff);
            last_in   = (rest_after == '0);
            error_in  = 1'b0;
            second_in = 1'b0;
            rest_in   = rest_after;
            busy_in   = (rest_after != '0);
         end else if (rne_pkg::term_second(pick) != rne_pkg::LetterNone) begin
            // subtractive pair: first letter now, second on the following emit
            letter_in = rne_pkg::term_first(pick);
            last_in   = 1'b0;
            error_in  = 1'b0;
            second_in = 1'b1;
            term_in   = pick;
         end else begin
            letter_in = rne_pkg::term_first(pick);
            last_in   = (rest_after == '0);
            error_in  = 1'b0;
            rest_in   = rest_after;
            busy_in   = (rest_after != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      term_ff   <= term_in;
      rest_ff   <= rest_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.letter = letter_ff;
   assign rsp_bus.last   = last_ff;
   assign rsp_bus.error  = error_ff;

   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && error_ff |-> last_ff && (letter_ff == rne_pkg::LetterNone))
      else $error("error beat not a lone last beat");

   a_second_busy: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> busy_ff && !err_ff)
      else $error("pending second letter while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      emit && last_in |=> !busy_ff)
      else $error("emitter still busy after last letter");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      pop |=> busy_ff)
      else $error("popped item not taken up");

endmodule

`default_nettype wire

FILE: hdl/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder: integer to Roman numeral, one letter per beat
// Front intake, item queue and letter emitter.
// ----------------------------------------------------------------------------
// Each request beat carries a 12-bit value; the block answers with its Roman
// numeral in standard form as a run of response beats, one 7-bit ASCII
// letter (M D C L X V I) per beat, the final one flagged by last. Only the
// subtractive pairs IV IX XL XC CD CM are used, so 99 gives XCIX and 3888
// gives the longest run, fifteen beats. A value of 0 produces no beats at
// all. Values 4000 to 4095 produce one beat with letter 0, last and error
// set. Timing: the emitter takes an item from the queue, then emits one
// letter per cycle while the response side does not stall; it takes no
// new item before the last letter of the current one is emitted. The
// one-letter-per-cycle emitter sets the sustained rate. The queue lets
// requests keep arriving while a numeral is being emitted, and a
// registered response stage lets the emitter pick up the next item while
// the previous last beat waits.
// ----------------------------------------------------------------------------
`default_nettype none

module roman_numeral_encoder #(
   parameter int QueueDepth = rne_pkg::QueueDepth  // item queue entries, 2 or more
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rne_req_if.sink    req_bus,
   rne_rsp_if.source  rsp_bus
);

   // front -> queue
   logic              push;
   rne_pkg::item_type push_item;
   logic              queue_full;

   // queue -> back
   logic              pop;
   rne_pkg::item_type pop_item;
   logic              queue_empty;

   // Intake: zero values are accepted and dropped here, out-of-range values
   // are tagged so the emitter sends a single error beat.
   rne_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   rne_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty)
   );

   // Emission: greedy subtraction of the largest fitting term, one letter
   // per cycle while the response register is free, into that register.
   rne_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire
